/* sv/assert_macros.svh */
// Assertion helpers used by the controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lzhmf_pkg.sv */
package lzhmf_pkg;

    localparam int INDEX_BITS_DEF    = 16;
    localparam int HISTORY_DEPTH_DEF = 65536;
    localparam logic [31:0] HASH_MULT = 32'h9e3779b9;
    localparam logic [8:0]  LEN_CAP   = 9'd256;
    localparam logic [8:0]  MAX_LEN_RESET = 9'd256;
    localparam logic [8:0]  MIN_LEN_RESET = 9'd4;

    localparam logic REG_MAX_LEN = 1'b0;
    localparam logic REG_MIN_LEN = 1'b1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // History read address source
    typedef enum logic [1:0] {
        HA_WORD = 2'd0,
        HA_PREV = 2'd1,
        HA_CUR  = 2'd2
    } hsel_t;

    // Controller commands to datapath
    typedef struct packed {
        logic       capture;     // latch input beat
        logic       hist_wr;     // write data byte to history
        logic       hist_rd;     // issue history read
        hsel_t      hist_sel;
        logic [1:0] word_idx;    // byte index of the word being gathered
        logic [1:0] base_k;      // offset of word base from query position
        logic       word_shift;  // take returned byte into word register
        logic       mul;         // register the product
        logic       tab_rd;      // read table at hash
        logic       tab_wr_cur;  // write table at hash with query position
        logic       tab_wr_ins;  // write table at hash with position + base_k
        logic       take_prev;   // latch table read data, compute distance
        logic       len_clr;
        logic       cmp_a;       // latch byte from previous position
        logic       len_inc;
        logic       clr_step;
    } lzhmf_cmd_t;

    typedef struct packed {
        logic kind;
        logic dist_zero;
        logic cmp_eq;      // latched byte equals returned byte
        logic len_at_lim;  // length reached limit
        logic len_ge_min;
        logic clr_last;
    } lzhmf_sts_t;

endpackage

/* sv/lzhmf_datapath.sv */
module lzhmf_datapath
    import lzhmf_pkg::*;
#(
    parameter int INDEX_BITS    = INDEX_BITS_DEF,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  lzhmf_cmd_t  cmd,
    output lzhmf_sts_t  sts,
    input  logic        in_kind,
    input  logic [15:0] in_position,
    input  logic [7:0]  in_data_byte,
    input  logic [8:0]  max_len,
    input  logic [8:0]  min_len,
    output logic [8:0]  len_out,
    output logic [15:0] dist_out
);
    localparam int HA = $clog2(HISTORY_DEPTH);
    localparam int TD = 1 << INDEX_BITS;

    logic [7:0]  hist_mem [HISTORY_DEPTH];
    logic [15:0] tab_mem  [TD];

    logic        kind_reg;
    logic [15:0] pos_reg;
    logic [7:0]  byte_reg;
    logic [31:0] word_reg;
    logic [31:0] prod_reg;
    logic [15:0] prev_reg;
    logic [15:0] dist_reg;
    logic [8:0]  len_reg;
    logic [7:0]  a_reg;
    logic [7:0]  hrd_reg;
    logic [15:0] trd_reg;
    logic [INDEX_BITS-1:0] clr_reg;

    logic [15:0] base;
    logic [15:0] addr16;
    logic [HA-1:0] haddr;
    logic [INDEX_BITS-1:0] hidx;
    logic [8:0] limit;

    assign base  = pos_reg + {14'd0, cmd.base_k};
    assign hidx  = prod_reg[31 -: INDEX_BITS];
    assign limit = (max_len > LEN_CAP) ? LEN_CAP : max_len;

    always_comb
    begin
        unique case (cmd.hist_sel)
            HA_WORD: addr16 = base + {14'd0, cmd.word_idx};
            HA_PREV: addr16 = prev_reg + {7'd0, len_reg};
            HA_CUR:  addr16 = pos_reg + {7'd0, len_reg};
            default: addr16 = base;
        endcase
    end
    assign haddr = addr16[HA-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.hist_wr)
            hist_mem[pos_reg[HA-1:0]] <= byte_reg;
        if (cmd.hist_rd)
            hrd_reg <= hist_mem[haddr];
        if (cmd.clr_step)
            tab_mem[clr_reg] <= 16'd0;
        else if (cmd.tab_wr_cur)
            tab_mem[hidx] <= pos_reg;
        else if (cmd.tab_wr_ins)
            tab_mem[hidx] <= base;
        if (cmd.tab_rd)
            trd_reg <= tab_mem[hidx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clr_step)
            clr_reg <= clr_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= in_kind;
            pos_reg  <= in_position;
            byte_reg <= in_data_byte;
        end
        if (cmd.word_shift)
            word_reg <= {hrd_reg, word_reg[31:8]};
        if (cmd.mul)
            prod_reg <= word_reg * HASH_MULT;
        if (cmd.take_prev)
        begin
            prev_reg <= trd_reg;
            dist_reg <= pos_reg - trd_reg;
        end
        if (cmd.cmp_a)
            a_reg <= hrd_reg;
        if (cmd.len_clr)
            len_reg <= 9'd0;
        else if (cmd.len_inc)
            len_reg <= len_reg + 9'd1;
    end

    assign sts.kind       = kind_reg;
    assign sts.dist_zero  = (dist_reg == 16'd0);
    assign sts.cmp_eq     = (a_reg == hrd_reg);
    assign sts.len_at_lim = (len_reg >= limit);
    assign sts.len_ge_min = (len_reg >= min_len);
    assign sts.clr_last   = (clr_reg == {INDEX_BITS{1'b1}});

    assign len_out  = sts.dist_zero ? 9'd0 : len_reg;
    assign dist_out = dist_reg;
endmodule

/* sv/lzhmf_ctrl.sv */
`include "assert_macros.svh"
module lzhmf_ctrl
    import lzhmf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  lzhmf_sts_t sts,
    output lzhmf_cmd_t cmd
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_WRD, S_WGET, S_MUL, S_TRD, S_TWR,
        S_PREV, S_CRA, S_CRB, S_CCMP, S_NEXT, S_INS, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] k_reg, k_next;
    logic       ovalid_next;
    logic       out_go;

    assign out_go   = out_valid && !out_stall;
    assign in_stall = !(state_reg == S_IDLE && !out_valid);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        ovalid_next = out_valid && !out_go;
        cmd         = '0;
        cmd.hist_sel = HA_WORD;
        cmd.word_idx = idx_reg;
        cmd.base_k   = k_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                // branch on captured kind
                if (sts.kind == KIND_LOAD)
                begin
                    cmd.hist_wr = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next   = 2'd0;
                    k_next     = 2'd0;
                    state_next = S_WRD;
                end
            end
            S_WRD:
            begin
                cmd.hist_rd = 1'b1;
                state_next  = S_WGET;
            end
            S_WGET:
            begin
                cmd.word_shift = 1'b1;
                idx_next = idx_reg + 2'd1;
                state_next = (idx_reg == 2'd3) ? S_MUL : S_WRD;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = (k_reg == 2'd0) ? S_TRD : S_INS;
            end
            S_TRD:
            begin
                cmd.tab_rd = 1'b1;
                state_next = S_TWR;
            end
            S_TWR:
            begin
                cmd.tab_wr_cur = 1'b1;
                cmd.take_prev  = 1'b1;
                cmd.len_clr    = 1'b1;
                state_next     = S_PREV;
            end
            S_PREV:
            begin
                if (sts.dist_zero)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_OUT;
                end
                else
                    state_next = S_CRA;
            end
            S_CRA:
            begin
                if (sts.len_at_lim)
                    state_next = S_NEXT;
                else
                begin
                    cmd.hist_rd  = 1'b1;
                    cmd.hist_sel = HA_PREV;
                    state_next   = S_CRB;
                end
            end
            S_CRB:
            begin
                cmd.cmp_a    = 1'b1;
                cmd.hist_rd  = 1'b1;
                cmd.hist_sel = HA_CUR;
                state_next   = S_CCMP;
            end
            S_CCMP:
            begin
                if (sts.cmp_eq)
                begin
                    cmd.len_inc = 1'b1;
                    state_next  = S_CRA;
                end
                else
                    state_next = S_NEXT;
            end
            S_NEXT:
            begin
                // insert next three positions when long enough
                if (sts.len_ge_min && k_reg != 2'd3)
                begin
                    k_next     = k_reg + 2'd1;
                    idx_next   = 2'd0;
                    state_next = S_WRD;
                end
                else
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_INS:
            begin
                cmd.tab_wr_ins = 1'b1;
                state_next     = S_NEXT;
            end
            S_OUT:
            begin
                if (!out_valid || out_go)
                    state_next = S_IDLE;
                if (out_go)
                    ovalid_next = 1'b0;
                else if (!out_valid)
                    ovalid_next = 1'b0;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= 2'd0;
            k_reg     <= 2'd0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
            out_valid <= ovalid_next;
        end
    end

    `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, in_stall, "accept while busy")
    `ASSERT_IMPL(a_clear_quiet, clk, rst_n, state_reg == S_CLEAR, !out_valid, "output during clear")
    `ASSERT_NEXT(a_out_from_prev, clk, rst_n, state_reg == S_PREV && sts.dist_zero, out_valid, "zero distance lost")
    `ASSERT_IMPL(a_one_table_wr, clk, rst_n, 1'b1, !(cmd.tab_wr_cur && cmd.tab_wr_ins), "double table write")
endmodule

/* sv/lz_hash_match_finder.sv */
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  kind, position, data_byte
// out       output     out_valid/out_stall match_length, match_distance
// cfg       input      cfg_we             cfg_index, cfg_data
//
// A load beat writes its byte to history. A query beat gathers the word at its
// position, hashes it, reads and updates the table and, unless the distance is
// zero, compares bytes, one history read at a time, to the limit or a mismatch,
// then inserts the three following positions if the length reaches the minimum.
// After reset a clearing pass zeroes the hash table under in_stall. out_stall
// holds the result; the next beat waits for it to leave.
module lz_hash_match_finder
    import lzhmf_pkg::*;
#(
    parameter int INDEX_BITS    = INDEX_BITS_DEF,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [15:0] position,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [8:0]  match_length,
    output logic [15:0] match_distance,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);
    lzhmf_cmd_t cmd;
    lzhmf_sts_t sts;
    logic [8:0] max_len_reg;
    logic [8:0] min_len_reg;

    // Register file: hold max and min match length.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
            min_len_reg <= MIN_LEN_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MAX_LEN)
                max_len_reg <= cfg_data;
            else
                min_len_reg <= cfg_data;
        end
    end

    lzhmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    lzhmf_datapath #(
        .INDEX_BITS    (INDEX_BITS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_kind      (kind),
        .in_position  (position),
        .in_data_byte (data_byte),
        .max_len      (max_len_reg),
        .min_len      (min_len_reg),
        .len_out      (match_length),
        .dist_out     (match_distance)
    );
endmodule
